// ===== rtl/stmm_pkg.sv =====
`timescale 1ns / 1ps
// package for the sparse triplet matrix multiply core
// holds command, status and state codes and the fixed field widths; no dependencies
package stmm_pkg;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 1'b1;

    // reset value of both dimension registers
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_CHK,
        S_P_RD,
        S_P_CHK,
        S_DONE,
        S_E_RD,
        S_EMIT,
        S_FLAG
    } t_state;

endpackage

// ===== rtl/stmm_in_if.sv =====
`timescale 1ns / 1ps
// input channel: command and triplet item with valid/ready handshake
// depends on stmm_pkg for the fixed field widths
interface stmm_in_if #(
    parameter int IW = 10
);
    logic                                  valid;
    logic                                  ready;
    logic [stmm_pkg::CMD_W-1:0]            cmd;
    logic [IW-1:0]                         elem_row;
    logic [IW-1:0]                         elem_col;
    logic signed [stmm_pkg::VALUE_W-1:0]   elem_value;

    modport source (output valid, cmd, elem_row, elem_col, elem_value, input ready);
    modport sink   (input valid, cmd, elem_row, elem_col, elem_value, output ready);
endinterface

// ===== rtl/stmm_out_if.sv =====
`timescale 1ns / 1ps
// output channel: product entry item with valid/ready handshake
// depends on stmm_pkg for the fixed field widths
interface stmm_out_if #(
    parameter int IW = 10
);
    logic                                  valid;
    logic                                  ready;
    logic [IW-1:0]                         out_row;
    logic [IW-1:0]                         out_col;
    logic signed [stmm_pkg::VALUE_W-1:0]   out_value;
    logic                                  out_last;
    logic [stmm_pkg::STATUS_W-1:0]         out_status;

    modport source (output valid, out_row, out_col, out_value, out_last, out_status,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, out_last, out_status,
                    output ready);
endinterface

// ===== rtl/stmm_ram.sv =====
`timescale 1ns / 1ps
// triplet store: one write port, one read port with registered read data
// no dependencies
module stmm_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 52,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sparse_triplet_matrix_multiply_core.sv =====
`timescale 1ns / 1ps
// sparse triplet matrix multiply core: a/b triplet stores, product store, sequencer
// depends on stmm_pkg, stmm_in_if, stmm_out_if and stmm_ram
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  i_in     | in  | valid/ready   | cmd, elem_row, elem_col, elem_value
//  o_out    | out | valid/ready   | out_row, out_col, out_value, out_last, out_status
//  cfg      | in  | i_cfg_we      | i_cfg_idx, i_cfg_data
//
// a load item leaves input ready high for the next; a compute item walks every (a, b)
// pair, fetching then checking it; a matching pair reads and checks product entries in
// turn and accumulates into a match or appends a new entry; each result item is then read
// and emitted, a flag item directly; the single read port of the product store sets this.
// reset clears all counts and sets both dimension registers to one; no clearing pass.
// input ready is held low from a compute item until its last result item is taken;
// a stalled result holds its payload.
module sparse_triplet_matrix_multiply_core #(
    parameter int CAPACITY    = 32,
    parameter int INDEX_WIDTH = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    stmm_in_if.sink                           i_in,
    stmm_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [stmm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [stmm_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int IW    = INDEX_WIDTH;
    localparam int VW    = stmm_pkg::VALUE_W;
    localparam int TW    = 2 * IW + VW;
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // control registers
    stmm_pkg::t_state  r_state, n_state;
    stmm_pkg::t_status r_flag, n_flag;
    logic [CW-1:0]     r_a_count, n_a_count;
    logic [CW-1:0]     r_b_count, n_b_count;
    logic [CW-1:0]     r_p_count, n_p_count;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_p, n_p;
    logic              r_dropped, n_dropped;
    logic [stmm_pkg::CFG_W-1:0] r_cfg_a, r_cfg_b;

    // payload registers of the pair being merged
    logic [IW-1:0]     r_row, n_row;
    logic [IW-1:0]     r_col, n_col;
    logic [VW-1:0]     r_prod, n_prod;

    // memory ports
    logic              a_we, b_we, p_we;
    logic [AW-1:0]     p_waddr;
    logic [TW-1:0]     load_data, p_wdata;
    logic [TW-1:0]     a_rd, b_rd, p_rd;

    // handshakes and decoded fields
    logic              in_acc, out_acc, do_adv, clr, e_last;
    stmm_pkg::t_cmd    cmd_in;
    logic [IW-1:0]     a_row, a_col, b_row, b_col, p_row, p_col;
    logic [VW-1:0]     a_val, b_val, p_val, mul_lo;

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = o_out.valid & o_out.ready;
    assign cmd_in  = stmm_pkg::t_cmd'(i_in.cmd);

    // triplet unpacking
    assign a_row = a_rd[TW-1 -: IW];
    assign a_col = a_rd[VW+IW-1 -: IW];
    assign a_val = a_rd[VW-1:0];
    assign b_row = b_rd[TW-1 -: IW];
    assign b_col = b_rd[VW+IW-1 -: IW];
    assign b_val = b_rd[VW-1:0];
    assign p_row = p_rd[TW-1 -: IW];
    assign p_col = p_rd[VW+IW-1 -: IW];
    assign p_val = p_rd[VW-1:0];

    assign mul_lo = VW'(a_val * b_val);
    assign e_last = ((r_p + ONE_C) == r_p_count);

    // load path into the a and b stores
    assign load_data = {i_in.elem_row, i_in.elem_col, i_in.elem_value};
    assign a_we = in_acc && (cmd_in == stmm_pkg::CMD_LOAD_A) && (r_a_count < CAP_C);
    assign b_we = in_acc && (cmd_in == stmm_pkg::CMD_LOAD_B) && (r_b_count < CAP_C);

    stmm_ram #(.DEPTH(CAPACITY), .WIDTH(TW)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_a_count[AW-1:0]),
        .i_wdata (load_data),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (a_rd)
    );

    stmm_ram #(.DEPTH(CAPACITY), .WIDTH(TW)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (r_b_count[AW-1:0]),
        .i_wdata (load_data),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (b_rd)
    );

    stmm_ram #(.DEPTH(CAPACITY), .WIDTH(TW)) u_p_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (r_p[AW-1:0]),
        .o_rdata (p_rd)
    );

    // handshake outputs and result payload
    assign i_in.ready  = (r_state == stmm_pkg::S_IDLE);
    assign o_out.valid = (r_state == stmm_pkg::S_EMIT) || (r_state == stmm_pkg::S_FLAG);

    always_comb begin
        if (r_state == stmm_pkg::S_EMIT) begin
            o_out.out_row    = p_row;
            o_out.out_col    = p_col;
            o_out.out_value  = p_val;
            o_out.out_last   = e_last;
            o_out.out_status = r_dropped ? stmm_pkg::ST_OVERFLOW : stmm_pkg::ST_OK;
        end else begin
            o_out.out_row    = '0;
            o_out.out_col    = '0;
            o_out.out_value  = '0;
            o_out.out_last   = 1'b1;
            o_out.out_status = r_flag;
        end
    end

    // next state and store control
    always_comb begin
        n_state   = r_state;
        n_flag    = r_flag;
        n_a_count = r_a_count;
        n_b_count = r_b_count;
        n_p_count = r_p_count;
        n_i       = r_i;
        n_j       = r_j;
        n_p       = r_p;
        n_dropped = r_dropped;
        n_row     = r_row;
        n_col     = r_col;
        n_prod    = r_prod;
        p_we      = 1'b0;
        p_waddr   = r_p_count[AW-1:0];
        p_wdata   = {r_row, r_col, r_prod};
        do_adv    = 1'b0;
        clr       = 1'b0;

        unique case (r_state)
            stmm_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (cmd_in)
                        stmm_pkg::CMD_LOAD_A: begin
                            if (r_a_count < CAP_C) n_a_count = r_a_count + ONE_C;
                        end
                        stmm_pkg::CMD_LOAD_B: begin
                            if (r_b_count < CAP_C) n_b_count = r_b_count + ONE_C;
                        end
                        stmm_pkg::CMD_COMPUTE: begin
                            n_i       = '0;
                            n_j       = '0;
                            n_p_count = '0;
                            n_dropped = 1'b0;
                            if (r_cfg_a != r_cfg_b) begin
                                n_flag  = stmm_pkg::ST_MISMATCH;
                                n_state = stmm_pkg::S_FLAG;
                            end else if (r_a_count == '0 || r_b_count == '0) begin
                                n_state = stmm_pkg::S_DONE;
                            end else begin
                                n_state = stmm_pkg::S_FETCH;
                            end
                        end
                        stmm_pkg::CMD_UNUSED: begin
                        end
                    endcase
                end
            end
            stmm_pkg::S_FETCH: begin
                n_state = stmm_pkg::S_CHK;
            end
            stmm_pkg::S_CHK: begin
                // pair matches when a column meets b row
                if (a_col == b_row) begin
                    n_row   = a_row;
                    n_col   = b_col;
                    n_prod  = mul_lo;
                    n_p     = '0;
                    n_state = stmm_pkg::S_P_RD;
                end else begin
                    do_adv = 1'b1;
                end
            end
            stmm_pkg::S_P_RD: begin
                // search ran past the filled entries: append or drop
                if (r_p == r_p_count) begin
                    if (r_p_count < CAP_C) begin
                        p_we      = 1'b1;
                        n_p_count = r_p_count + ONE_C;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    do_adv = 1'b1;
                end else begin
                    n_state = stmm_pkg::S_P_CHK;
                end
            end
            stmm_pkg::S_P_CHK: begin
                // accumulate into the matching entry, else move on to the next entry
                if (p_row == r_row && p_col == r_col) begin
                    p_we    = 1'b1;
                    p_waddr = r_p[AW-1:0];
                    p_wdata = {r_row, r_col, VW'(p_val + r_prod)};
                    do_adv  = 1'b1;
                end else begin
                    n_p     = r_p + ONE_C;
                    n_state = stmm_pkg::S_P_RD;
                end
            end
            stmm_pkg::S_DONE: begin
                if (r_p_count == '0) begin
                    n_flag  = stmm_pkg::ST_EMPTY;
                    n_state = stmm_pkg::S_FLAG;
                end else begin
                    n_p     = '0;
                    n_state = stmm_pkg::S_E_RD;
                end
            end
            stmm_pkg::S_E_RD: begin
                n_state = stmm_pkg::S_EMIT;
            end
            stmm_pkg::S_EMIT: begin
                if (out_acc) begin
                    if (e_last) begin
                        clr = 1'b1;
                    end else begin
                        n_p     = r_p + ONE_C;
                        n_state = stmm_pkg::S_E_RD;
                    end
                end
            end
            stmm_pkg::S_FLAG: begin
                if (out_acc) clr = 1'b1;
            end
        endcase

        // step to the next (a, b) pair, b inner
        if (do_adv) begin
            if ((r_j + ONE_C) == r_b_count) begin
                n_j = '0;
                if ((r_i + ONE_C) == r_a_count) begin
                    n_state = stmm_pkg::S_DONE;
                end else begin
                    n_i     = r_i + ONE_C;
                    n_state = stmm_pkg::S_FETCH;
                end
            end else begin
                n_j     = r_j + ONE_C;
                n_state = stmm_pkg::S_FETCH;
            end
        end

        // compute finished: all counts clear
        if (clr) begin
            n_a_count = '0;
            n_b_count = '0;
            n_p_count = '0;
            n_state   = stmm_pkg::S_IDLE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= stmm_pkg::S_IDLE;
            r_flag    <= stmm_pkg::ST_OK;
            r_a_count <= '0;
            r_b_count <= '0;
            r_p_count <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_p       <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_flag    <= n_flag;
            r_a_count <= n_a_count;
            r_b_count <= n_b_count;
            r_p_count <= n_p_count;
            r_i       <= n_i;
            r_j       <= n_j;
            r_p       <= n_p;
            r_dropped <= n_dropped;
        end
    end

    // pair payload
    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_prod <= n_prod;
    end

    // dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_a <= stmm_pkg::CFG_RESET;
            r_cfg_b <= stmm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                stmm_pkg::CFG_A_COLS: r_cfg_a <= i_cfg_data;
                stmm_pkg::CFG_B_ROWS: r_cfg_b <= i_cfg_data;
            endcase
        end
    end

    // product store never overfills
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_count <= CAP_C)
        else $error("product entry count beyond capacity");

    // pair walk stays within the loaded entries
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stmm_pkg::S_FETCH || r_state == stmm_pkg::S_CHK)
        |-> (r_i < r_a_count && r_j < r_b_count))
        else $error("pair walk index out of range");

    // entry search reads only filled entries
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stmm_pkg::S_P_CHK) |-> (r_p < r_p_count))
        else $error("product search beyond filled entries");

    // no item taken while a result is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while result pending");

    // last result of a compute clears all counts
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.out_last)
        |=> (r_a_count == '0 && r_b_count == '0 && r_p_count == '0
             && r_state == stmm_pkg::S_IDLE))
        else $error("counts not cleared after compute");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench for the sparse triplet matrix multiply core: a directed table, then random load/compute
// phases; every result item is checked against a predictor or a table result. depends on
// stmm_pkg, stmm_in_if, stmm_out_if and sparse_triplet_matrix_multiply_core
module testbench;

    localparam int CAPACITY     = 32;
    localparam int IW           = 10;
    localparam int VW           = stmm_pkg::VALUE_W;
    localparam int RANDOM_ITEMS = 100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LOAD_SETTLE  = 4;

    typedef struct {
        logic [IW-1:0]      row;
        logic [IW-1:0]      col;
        logic [VW-1:0]      value;
    } t_triplet;

    typedef struct {
        logic [IW-1:0]      row;
        logic [IW-1:0]      col;
        logic [VW-1:0]      value;
        logic               last;
        stmm_pkg::t_status  status;
    } t_entry;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one line of the directed table; a config line keeps its register index in row
    typedef struct {
        t_row_kind          kind;
        stmm_pkg::t_cmd     cmd;
        logic [IW-1:0]      row;
        logic [IW-1:0]      col;
        logic [VW-1:0]      value;
        int                 rep;
        bit                 typed;
        t_entry             result;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [stmm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [stmm_pkg::CFG_W-1:0]     i_cfg_data;

    stmm_in_if  #(.IW(IW)) in_ch ();
    stmm_out_if #(.IW(IW)) out_ch ();

    sparse_triplet_matrix_multiply_core #(
        .CAPACITY    (CAPACITY),
        .INDEX_WIDTH (IW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [stmm_pkg::CFG_W-1:0] a_cols_reg;
    logic [stmm_pkg::CFG_W-1:0] b_rows_reg;
    t_triplet         a_store [CAPACITY];
    t_triplet         b_store [CAPACITY];
    t_triplet         prod_store [CAPACITY];
    int               a_count;
    int               b_count;

    t_entry    predicted_entries [$];
    t_entry    awaited_entries [$];
    t_stim_row directed_rows [$];
    t_entry    no_entry;

    int error_count = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    int big_phases  = 0;
    int send_calm   = 0;
    int take_calm   = 0;

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // product of the two stores, entries in order of creation
    function automatic void multiply_triplets();
        logic [VW-1:0]      prod;
        int                 n;
        bit                 found;
        bit                 dropped;
        n = 0;
        dropped = 1'b0;
        if (a_cols_reg != b_rows_reg) begin
            predicted_entries.push_back('{10'd0, 10'd0, 32'd0, 1'b1,
                                          stmm_pkg::ST_MISMATCH});
            return;
        end
        for (int i = 0; i < a_count; i++) begin
            for (int j = 0; j < b_count; j++) begin
                if (a_store[i].col != b_store[j].row) continue;
                prod = a_store[i].value * b_store[j].value;
                found = 1'b0;
                for (int p = 0; p < n; p++) begin
                    if (prod_store[p].row == a_store[i].row &&
                        prod_store[p].col == b_store[j].col) begin
                        prod_store[p].value = prod_store[p].value + prod;
                        found = 1'b1;
                        break;
                    end
                end
                if (!found) begin
                    if (n < CAPACITY) begin
                        prod_store[n] = '{a_store[i].row, b_store[j].col, prod};
                        n++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
            end
        end
        if (n == 0) begin
            predicted_entries.push_back('{10'd0, 10'd0, 32'd0, 1'b1, stmm_pkg::ST_EMPTY});
            return;
        end
        for (int k = 0; k < n; k++)
            predicted_entries.push_back('{prod_store[k].row, prod_store[k].col,
                                          prod_store[k].value, k == n - 1,
                                          dropped ? stmm_pkg::ST_OVERFLOW
                                                  : stmm_pkg::ST_OK});
    endfunction

    // effect of one accepted item on the predictor
    function automatic void predict_item(input stmm_pkg::t_cmd cmd,
                                         input logic [IW-1:0] row, col,
                                         input logic [VW-1:0] value);
        predicted_entries.delete();
        case (cmd)
            stmm_pkg::CMD_LOAD_A: begin
                if (a_count < CAPACITY) begin
                    a_store[a_count] = '{row, col, value};
                    a_count++;
                end
            end
            stmm_pkg::CMD_LOAD_B: begin
                if (b_count < CAPACITY) begin
                    b_store[b_count] = '{row, col, value};
                    b_count++;
                end
            end
            stmm_pkg::CMD_COMPUTE: begin
                multiply_triplets();
                a_count = 0;
                b_count = 0;
            end
            default: ;
        endcase
    endfunction

    // wait before the next handshake, with runs of back-to-back items
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // mostly small indices so that columns of A meet rows of B
    function automatic logic [IW-1:0] pick_index();
        if ($urandom_range(0, 3) == 0) return IW'($urandom);
        return IW'($urandom_range(0, 3));
    endfunction

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return VW'($urandom_range(0, 9));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [stmm_pkg::CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 5))
            0: return 11'd1;
            1: return 11'd1024;
            2: return 11'd0;
            3: return 11'd2047;
            default: return stmm_pkg::CFG_W'($urandom_range(1, 1024));
        endcase
    endfunction

    // directed table lines
    function automatic void item_row(input stmm_pkg::t_cmd cmd, input logic [IW-1:0] row, col,
                                     input logic [VW-1:0] value, input int rep);
        t_stim_row r;
        r = '{ROW_ITEM, cmd, row, col, value, rep, 1'b0, no_entry};
        directed_rows.push_back(r);
    endfunction

    function automatic void checked_row(input logic [IW-1:0] row, col,
                                        input logic [VW-1:0] value,
                                        input stmm_pkg::t_status status);
        t_stim_row r;
        r = '{ROW_ITEM, stmm_pkg::CMD_COMPUTE, 10'd0, 10'd0, 32'd0, 1, 1'b1,
              '{row, col, value, 1'b1, status}};
        directed_rows.push_back(r);
    endfunction

    function automatic void cfg_row(input logic [stmm_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [stmm_pkg::CFG_W-1:0] data);
        t_stim_row r;
        r = '{ROW_CFG, stmm_pkg::CMD_UNUSED, IW'(idx), 10'd0, VW'(data), 1, 1'b0, no_entry};
        directed_rows.push_back(r);
    endfunction

    function automatic void field_differs(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // compare one result item with the oldest expectation
    function automatic void check_entry(input t_entry got);
        t_entry want;
        if (awaited_entries.size() == 0) begin
            $display("%0t ns: unexpected result row %0d col %0d value %h last %b status %0d",
                     $time, got.row, got.col, got.value, got.last, got.status);
            error_count++;
            return;
        end
        want = awaited_entries.pop_front();
        field_differs("out_row", 32'(want.row), 32'(got.row));
        field_differs("out_col", 32'(want.col), 32'(got.col));
        field_differs("out_value", want.value, got.value);
        field_differs("out_last", 32'(want.last), 32'(got.last));
        field_differs("out_status", 32'(want.status), 32'(got.status));
    endfunction

    // drive one input item and note what it should produce
    task automatic send_item(input stmm_pkg::t_cmd cmd, input logic [IW-1:0] row, col,
                             input logic [VW-1:0] value, input bit typed,
                             input t_entry typed_result);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.elem_row   <= row;
        in_ch.elem_col   <= col;
        in_ch.elem_value <= value;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_item(cmd, row, col, value);
        if (typed)
            awaited_entries.push_back(typed_result);
        else
            foreach (predicted_entries[k]) awaited_entries.push_back(predicted_entries[k]);
        if (cmd != stmm_pkg::CMD_UNUSED) items_sent++;
    endtask

    // register write once the block has gone quiet
    task automatic write_dim_reg(input logic [stmm_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [stmm_pkg::CFG_W-1:0] data);
        in_ch.valid <= 1'b0;
        while (awaited_entries.size() != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == stmm_pkg::CFG_A_COLS)
            a_cols_reg = data;
        else
            b_rows_reg = data;
    endtask

    // one random phase: maybe new dimensions, a shuffle of loads with some noise, then a compute
    task automatic run_random_phase();
        logic [stmm_pkg::CFG_W-1:0] a_dim;
        logic [stmm_pkg::CFG_W-1:0] b_dim;
        int               na;
        int               nb;
        bit               to_a;
        if ($urandom_range(0, 2) == 0) begin
            a_dim = pick_dim();
            b_dim = a_dim;
            if ($urandom_range(0, 4) == 0)
                b_dim = a_dim ^ (stmm_pkg::CFG_W'(1)
                                 << $urandom_range(0, stmm_pkg::CFG_W - 1));
            write_dim_reg(stmm_pkg::CFG_A_COLS, a_dim);
            write_dim_reg(stmm_pkg::CFG_B_ROWS, b_dim);
        end
        na = $urandom_range(0, 6);
        nb = $urandom_range(0, 6);
        // up to three phases load 30 to 35 items into A, which can overfill the A store
        if (big_phases < 3 && $urandom_range(0, 9) == 0) begin
            na = $urandom_range(30, 35);
            big_phases++;
        end
        while (na + nb > 0) begin
            if ($urandom_range(0, 11) == 0)
                send_item(stmm_pkg::CMD_UNUSED, pick_index(), pick_index(), pick_value(),
                          1'b0, no_entry);
            to_a = ($urandom_range(1, na + nb) <= na);
            if (to_a) begin
                send_item(stmm_pkg::CMD_LOAD_A, pick_index(), pick_index(), pick_value(),
                          1'b0, no_entry);
                na--;
            end else begin
                send_item(stmm_pkg::CMD_LOAD_B, pick_index(), pick_index(), pick_value(),
                          1'b0, no_entry);
                nb--;
            end
        end
        send_item(stmm_pkg::CMD_COMPUTE, pick_index(), pick_index(), pick_value(),
                  1'b0, no_entry);
    endtask

    // result side: random stalls, every accepted item checked
    initial begin
        t_entry got;
        int     stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            got = '{out_ch.out_row, out_ch.out_col, out_ch.out_value, out_ch.out_last,
                    stmm_pkg::t_status'(out_ch.out_status)};
            check_entry(got);
        end
    end

    // stimulus
    initial begin
        t_stim_row r;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = stmm_pkg::CFG_A_COLS;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = stmm_pkg::CMD_LOAD_A;
        in_ch.elem_row   = '0;
        in_ch.elem_col   = '0;
        in_ch.elem_value = '0;
        out_ch.ready     = 1'b0;
        a_cols_reg       = stmm_pkg::CFG_RESET;
        b_rows_reg       = stmm_pkg::CFG_RESET;
        a_count          = 0;
        b_count          = 0;
        no_entry         = '{10'd0, 10'd0, 32'd0, 1'b0, stmm_pkg::ST_OK};

        // compute straight after reset: dimensions equal, nothing loaded
        checked_row(10'd0, 10'd0, 32'd0, stmm_pkg::ST_EMPTY);
        // unused command leaves no trace
        item_row(stmm_pkg::CMD_UNUSED, 10'd5, 10'd5, 32'd123, 1);
        // top indices, most negative times minus one wraps back to itself
        item_row(stmm_pkg::CMD_LOAD_A, 10'd1023, 10'd1023, 32'h8000_0000, 1);
        item_row(stmm_pkg::CMD_LOAD_B, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 1);
        checked_row(10'd1023, 10'd1023, 32'h8000_0000, stmm_pkg::ST_OK);
        // accumulation into one entry, a second entry, an A item with no partner
        item_row(stmm_pkg::CMD_LOAD_A, 10'd5, 10'd1, 32'd3, 1);
        item_row(stmm_pkg::CMD_LOAD_A, 10'd5, 10'd2, 32'd4, 1);
        item_row(stmm_pkg::CMD_LOAD_A, 10'd6, 10'd3, 32'h7FFF_FFFF, 1);
        item_row(stmm_pkg::CMD_LOAD_B, 10'd1, 10'd7, 32'd10, 1);
        item_row(stmm_pkg::CMD_LOAD_B, 10'd2, 10'd7, 32'd20, 1);
        item_row(stmm_pkg::CMD_LOAD_B, 10'd2, 10'd0, 32'hFFFF_FFFF, 1);
        item_row(stmm_pkg::CMD_COMPUTE, 10'd0, 10'd0, 32'd0, 1);
        // dimension mismatch
        cfg_row(stmm_pkg::CFG_A_COLS, 11'd1024);
        checked_row(10'd0, 10'd0, 32'd0, stmm_pkg::ST_MISMATCH);
        cfg_row(stmm_pkg::CFG_B_ROWS, 11'd1024);
        // 33 loads into A (last one ignored), 64 products for 32 entries: overflow
        item_row(stmm_pkg::CMD_LOAD_A, 10'd0, 10'd0, 32'd1, 33);
        item_row(stmm_pkg::CMD_LOAD_B, 10'd0, 10'd0, 32'd1, 1);
        item_row(stmm_pkg::CMD_LOAD_B, 10'd0, 10'd1, 32'hFFFF_FFFE, 1);
        item_row(stmm_pkg::CMD_COMPUTE, 10'd0, 10'd0, 32'd0, 1);
        // a zero product still makes an entry
        item_row(stmm_pkg::CMD_LOAD_A, 10'd3, 10'd4, 32'd0, 1);
        item_row(stmm_pkg::CMD_LOAD_B, 10'd4, 10'd9, 32'd5, 1);
        item_row(stmm_pkg::CMD_COMPUTE, 10'd0, 10'd0, 32'd0, 1);
        // back to reset dimensions; A alone gives an empty product
        cfg_row(stmm_pkg::CFG_A_COLS, 11'd1);
        cfg_row(stmm_pkg::CFG_B_ROWS, 11'd1);
        item_row(stmm_pkg::CMD_LOAD_A, 10'd1, 10'd2, 32'd3, 1);
        checked_row(10'd0, 10'd0, 32'd0, stmm_pkg::ST_EMPTY);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[n]) begin
            r = directed_rows[n];
            if (r.kind == ROW_CFG)
                write_dim_reg(stmm_pkg::CFG_IDX_W'(r.row), stmm_pkg::CFG_W'(r.value));
            else
                for (int k = 0; k < r.rep; k++)
                    send_item(r.cmd, r.row + IW'(k), r.col, r.value + VW'(k),
                              r.typed, r.result);
        end

        // random phases
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) run_random_phase();

        in_ch.valid <= 1'b0;
        while (awaited_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
